// File: hdl/efd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efd_pkg
// Shared types and register index codes for the escaped frame deframer.
// ----------------------------------------------------------------------------
package efd_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_START_CODE  = 2'd0;
    localparam logic [1:0] REG_END_CODE    = 2'd1;
    localparam logic [1:0] REG_ESCAPE_CODE = 2'd2;

    // reset values of the control codes
    localparam logic [7:0] START_CODE_RST  = 8'h02;
    localparam logic [7:0] END_CODE_RST    = 8'h03;
    localparam logic [7:0] ESCAPE_CODE_RST = 8'h06;

    // field widths of a result beat
    localparam int unsigned POS_W  = 6;
    localparam int unsigned BYTE_W = 8;

    // control codes as currently programmed
    typedef struct packed {
        logic [7:0] start_code;
        logic [7:0] end_code;
        logic [7:0] escape_code;
    } efd_codes_t;

    // one result beat
    typedef struct packed {
        logic              overflow;
        logic [POS_W-1:0]  frame_length;
        logic              frame_done;
        logic [BYTE_W-1:0] store_byte;
        logic [POS_W-1:0]  store_index;
        logic              store_valid;
    } efd_result_t;

endpackage

// File: hdl/efd_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efd_step
// Per-byte deframing logic: next frame state and the result for one byte.
// ----------------------------------------------------------------------------
module efd_step #(
    parameter int BUFFER_SIZE = 64
) (
    input  efd_pkg::efd_codes_t                  codes,
    input  logic [7:0]                           rx_byte,
    input  logic                                 in_frame,
    input  logic                                 escape_pending,
    input  logic [$clog2(BUFFER_SIZE)-1:0]       write_index,
    output logic                                 in_frame_next,
    output logic                                 escape_pending_next,
    output logic [$clog2(BUFFER_SIZE)-1:0]       write_index_next,
    output efd_pkg::efd_result_t                 result
);
    import efd_pkg::*;

    localparam int IDX_W = $clog2(BUFFER_SIZE);
    localparam int EXT_W = (IDX_W > POS_W) ? IDX_W : POS_W;

    logic [IDX_W:0]     idx_inc;
    logic               advance;
    logic [EXT_W-1:0]   idx_ext;

    assign idx_inc = {1'b0, write_index} + {{IDX_W{1'b0}}, 1'b1};
    assign idx_ext = EXT_W'(write_index);

    // control code decode and index update
    always_comb
    begin
        in_frame_next       = in_frame;
        escape_pending_next = escape_pending;
        write_index_next    = write_index;
        advance             = 1'b0;
        result              = '0;

        // every byte inside an open frame is offered for storing
        if (in_frame)
        begin
            result.store_valid = 1'b1;
            result.store_index = idx_ext[POS_W-1:0];
            result.store_byte  = rx_byte;
        end

        if (!escape_pending || !in_frame)
        begin
            // escape wins over start, start over end
            if (rx_byte == codes.escape_code)
            begin
                escape_pending_next = 1'b1;
            end
            else if (rx_byte == codes.start_code)
            begin
                write_index_next = '0;
                in_frame_next    = 1'b1;
            end
            else if (rx_byte == codes.end_code)
            begin
                if (in_frame)
                begin
                    result.frame_done   = 1'b1;
                    result.frame_length = idx_ext[POS_W-1:0];
                end
                in_frame_next = 1'b0;
            end
            else if (in_frame)
            begin
                advance = 1'b1;
            end
        end
        else
        begin
            // literal byte after an escape
            escape_pending_next = 1'b0;
            advance             = 1'b1;
        end

        // index step, with overflow back to the idle state
        if (advance)
        begin
            if (idx_inc == (IDX_W + 1)'(BUFFER_SIZE))
            begin
                in_frame_next       = 1'b0;
                escape_pending_next = 1'b0;
                write_index_next    = '0;
                result.overflow     = 1'b1;
            end
            else
            begin
                write_index_next = idx_inc[IDX_W-1:0];
            end
        end
    end

endmodule

// File: hdl/escaped_frame_deframer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escaped_frame_deframer_unit
// Byte-stuffed frame receiver: start, end and escape codes delimit frames.
// ----------------------------------------------------------------------------
// Usage
// - s_* stream: one raw link byte per beat in s_tdata[7:0].
// - m_* stream: one result beat per input byte. m_tdata carries the store
//   request (valid, index, byte), the closed frame length and the overflow
//   flag; m_tlast marks the beat on which an end code closed a frame.
// - cfg_we/cfg_index/cfg_data program the start, end and escape codes;
//   write them only while no byte is in flight.
// Timing
// - a byte is captured in the input register, then decoded against the
//   frame state into the result register that drives the result beat.
// - one byte per cycle sustained while m_tready stays high; the frame state
//   update is a single compare-and-increment step between the two registers.
// - when m_tready is low the result register holds, the input register
//   fills and s_tready drops; no beat is lost.
// - reset empties both registers, closes any frame and restores the codes
//   to start 0x02, end 0x03, escape 0x06.
// ----------------------------------------------------------------------------
module escaped_frame_deframer_unit #(
    parameter int BUFFER_SIZE = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [0] store_valid, [6:1] store_index,
                                   // [14:7] store_byte, [20:15] frame_length,
                                   // [21] overflow, [23:22] zero
    output logic        m_tlast    // frame_done
);
    import efd_pkg::*;

    localparam int IDX_W = $clog2(BUFFER_SIZE);

    efd_codes_t         codes_reg;
    logic               in_valid_reg;
    logic [7:0]         in_byte_reg;
    logic               out_valid_reg;
    efd_result_t        out_reg;
    logic               in_frame_reg;
    logic               escape_pending_reg;
    logic [IDX_W-1:0]   write_index_reg;

    logic               in_frame_next;
    logic               escape_pending_next;
    logic [IDX_W-1:0]   write_index_next;
    efd_result_t        result_next;
    logic               advance;

    // pipeline moves when the result register is free or being drained
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            codes_reg.start_code  <= START_CODE_RST;
            codes_reg.end_code    <= END_CODE_RST;
            codes_reg.escape_code <= ESCAPE_CODE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_START_CODE:  codes_reg.start_code  <= cfg_data;
                REG_END_CODE:    codes_reg.end_code    <= cfg_data;
                REG_ESCAPE_CODE: codes_reg.escape_code <= cfg_data;
                default:         ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
        end
    end

    // deframing step
    efd_step #(
        .BUFFER_SIZE (BUFFER_SIZE)
    ) u_step (
        .codes               (codes_reg),
        .rx_byte             (in_byte_reg),
        .in_frame            (in_frame_reg),
        .escape_pending      (escape_pending_reg),
        .write_index         (write_index_reg),
        .in_frame_next       (in_frame_next),
        .escape_pending_next (escape_pending_next),
        .write_index_next    (write_index_next),
        .result              (result_next)
    );

    // frame state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg       <= 1'b0;
            escape_pending_reg <= 1'b0;
            write_index_reg    <= '0;
            out_valid_reg      <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg)
            begin
                in_frame_reg       <= in_frame_next;
                escape_pending_reg <= escape_pending_next;
                write_index_reg    <= write_index_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            out_reg <= result_next;
        end
    end

    // output packing
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg.overflow, out_reg.frame_length,
                       out_reg.store_byte, out_reg.store_index, out_reg.store_valid};
    assign m_tlast  = out_reg.frame_done;

    // a closing end code is itself stored, as is the byte that overflows
    a_done_stores : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && out_reg.frame_done |-> out_reg.store_valid)
        else $error("frame_done without a store");

    a_ovf_stores : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && out_reg.overflow |-> out_reg.store_valid)
        else $error("overflow without a store");

    a_done_ovf_excl : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(out_reg.frame_done && out_reg.overflow))
        else $error("frame_done and overflow on the same beat");

    // overflow leaves the frame closed with a cleared index
    a_ovf_resets : assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_valid_reg && result_next.overflow |=>
        !in_frame_reg && !escape_pending_reg && (write_index_reg == '0))
        else $error("frame state not cleared after overflow");

    // backpressure only when the input register is occupied
    a_stall_full : assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("input stalled with room in the pipeline");

endmodule
